[src/bps_pkg.sv]
// Shared package of the Blinn-Phong shader: register indexes, fixed-point widths,
// stage counts and the constant functions that build the exp2 table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bps_pkg;

  localparam int VECTOR_WIDTH_DEF = 16;
  localparam int COLOR_WIDTH_DEF  = 16;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_DIFFUSE_RED    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DIFFUSE_GREEN  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DIFFUSE_BLUE   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPECULAR_RED   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SPECULAR_GREEN = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SPECULAR_BLUE  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SHININESS      = 3'd6;

  // Base of the power in Q.14, from 0 to 1.0, and the Q.30 factor.
  localparam int BASE_W   = 15;
  localparam int FACTOR_W = 31;
  localparam logic [BASE_W-1:0]   ONE14 = 15'd16384;
  localparam logic [FACTOR_W-1:0] ONE30 = 31'h4000_0000;

  localparam int SQ_STEPS  = 17;  // root bits of a 34-bit square length
  localparam int DIV_STEPS = 15;  // quotient bits below the clamp check
  localparam int LOG_BITS  = 16;  // fraction bits of log2 and of exp2

  typedef enum logic [1:0] {
    PW_CALC,
    PW_ONE,
    PW_ZERO
  } pw_code_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] v;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    v = x;
    for (int k = 0; k < 32; k++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Entry n is 2^(-2^-n) in Q.30, each entry the root of the one before.
  function automatic logic [29:0] exp_tab(input int n);
    logic [63:0] t;
    t = isqrt64(64'd1 << 59);
    for (int k = 2; k <= LOG_BITS; k++) begin
      if (k <= n) begin
        t = isqrt64(t << 30);
      end
    end
    return t[29:0];
  endfunction

endpackage

`default_nettype wire

[src/bps_if.sv]
// Valid/ready channel interfaces of the Blinn-Phong shader: shading requests and
// shaded colors. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface bps_req_if #(
  parameter int VECTOR_WIDTH = 16,
  parameter int COLOR_WIDTH  = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [VECTOR_WIDTH-1:0] view_x;
  logic signed [VECTOR_WIDTH-1:0] view_y;
  logic signed [VECTOR_WIDTH-1:0] view_z;
  logic signed [VECTOR_WIDTH-1:0] normal_x;
  logic signed [VECTOR_WIDTH-1:0] normal_y;
  logic signed [VECTOR_WIDTH-1:0] normal_z;
  logic signed [VECTOR_WIDTH-1:0] light_dir_x;
  logic signed [VECTOR_WIDTH-1:0] light_dir_y;
  logic signed [VECTOR_WIDTH-1:0] light_dir_z;
  logic        [COLOR_WIDTH-1:0]  light_red;
  logic        [COLOR_WIDTH-1:0]  light_green;
  logic        [COLOR_WIDTH-1:0]  light_blue;

  modport source (
    output valid, view_x, view_y, view_z, normal_x, normal_y, normal_z,
           light_dir_x, light_dir_y, light_dir_z, light_red, light_green, light_blue,
    input  ready
  );
  modport sink (
    input  valid, view_x, view_y, view_z, normal_x, normal_y, normal_z,
           light_dir_x, light_dir_y, light_dir_z, light_red, light_green, light_blue,
    output ready
  );
endinterface

interface bps_rsp_if #(
  parameter int COLOR_WIDTH = 16
);
  logic                 valid;
  logic                 ready;
  logic [COLOR_WIDTH:0] shade_red;
  logic [COLOR_WIDTH:0] shade_green;
  logic [COLOR_WIDTH:0] shade_blue;

  modport source (output valid, shade_red, shade_green, shade_blue, input ready);
  modport sink (input valid, shade_red, shade_green, shade_blue, output ready);
endinterface

`default_nettype wire

[src/blinn_phong_shader_unit.sv]
// Blinn-Phong shading unit: one shaded color per shading request.
// Channels:  req (bps_req_if sink) carries V, N, L and the light color;
//            rsp (bps_rsp_if source) carries the shaded red, green and blue.
// Both channels move a transaction at a rising edge with valid and ready high.
// Materials and shininess are written through cfg_write/cfg_index/cfg_data;
// the user must write them only while no transaction is in flight; the block does
// not enforce it; an index above six is ignored. Throughput: one transaction
// per cycle while the receiver is ready, every stage holds an item of its own.
// Stages: 3 for conversion, products and dot sums, 17 for the bit-serial square
// root of |H|^2, 16 for the restoring division N.H / |H|, 35 in the power unit
// (normalize, 16 squaring steps of log2, scaling, 16 table steps of exp2, final
// shift) and 3 for the color terms and the saturating sum.
// Each stage has a valid bit and loads when it is empty or the next one loads,
// so a stalled receiver only halts the full stages behind the result; bubbles
// close up and req.ready stays high while the first stage can move.
// Synchronous reset clears the valid bits and the material registers; payload
// registers are not reset.
// Depends on bps_pkg, bps_if and bps_power.
`timescale 1ns / 1ps
`default_nettype none

module blinn_phong_shader_unit #(
  parameter int VECTOR_WIDTH = bps_pkg::VECTOR_WIDTH_DEF,
  parameter int COLOR_WIDTH  = bps_pkg::COLOR_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  bps_req_if.sink                         req,
  bps_rsp_if.source                       rsp,
  input  logic                            cfg_write,
  input  logic [bps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bps_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW       = COLOR_WIDTH;
  localparam int SIDE_W   = 15 + 3 * CW;
  localparam int SQ       = bps_pkg::SQ_STEPS;
  localparam int DV       = bps_pkg::DIV_STEPS;
  localparam int ST_SQRT  = 4;
  localparam int ST_DPRE  = ST_SQRT + SQ;
  localparam int ST_DIV   = ST_DPRE + 1;
  localparam int NA       = ST_DIV + DV - 1;
  localparam int NB       = 3;

  // Material registers.
  logic [CW-1:0] mat_dif [3];
  logic [CW-1:0] mat_spc [3];
  logic [15:0]   shininess;

  always_ff @(posedge clk) begin
    if (rst) begin
      mat_dif   <= '{default: '0};
      mat_spc   <= '{default: '0};
      shininess <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bps_pkg::REG_DIFFUSE_RED:    mat_dif[0] <= CW'(cfg_data);
        bps_pkg::REG_DIFFUSE_GREEN:  mat_dif[1] <= CW'(cfg_data);
        bps_pkg::REG_DIFFUSE_BLUE:   mat_dif[2] <= CW'(cfg_data);
        bps_pkg::REG_SPECULAR_RED:   mat_spc[0] <= CW'(cfg_data);
        bps_pkg::REG_SPECULAR_GREEN: mat_spc[1] <= CW'(cfg_data);
        bps_pkg::REG_SPECULAR_BLUE:  mat_spc[2] <= CW'(cfg_data);
        bps_pkg::REG_SHININESS:      shininess  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid/ready chain of the front pipeline, up to the power unit.
  logic [NA:1]   vld_a;
  logic [NA+1:1] rdy_a;
  logic [NA:1]   vld_a_prev;
  logic          pw_in_ready;

  assign vld_a_prev = {vld_a[NA-1:1], req.valid};
  assign rdy_a[NA+1] = pw_in_ready;
  assign req.ready = rdy_a[1];

  for (genvar k = 1; k <= NA; k++) begin : g_rdy_a
    assign rdy_a[k] = !vld_a[k] || rdy_a[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= '0;
    end else begin
      for (int k = 1; k <= NA; k++) begin
        if (rdy_a[k]) begin
          vld_a[k] <= vld_a_prev[k];
        end
      end
    end
  end

  // Scale a component to Q.14 with a floor on the dropped bits.
  function automatic logic signed [15:0] to_q14(input logic signed [VECTOR_WIDTH-1:0] raw);
    logic signed [VECTOR_WIDTH+15:0] wide;
    logic signed [VECTOR_WIDTH+15:0] shifted;
    wide    = {raw, 16'h0000};
    shifted = wide >>> VECTOR_WIDTH;
    return shifted[15:0];
  endfunction

  logic signed [VECTOR_WIDTH-1:0] in_v [3];
  logic signed [VECTOR_WIDTH-1:0] in_n [3];
  logic signed [VECTOR_WIDTH-1:0] in_l [3];
  logic        [CW-1:0]           in_c [3];

  assign in_v = '{req.view_x, req.view_y, req.view_z};
  assign in_n = '{req.normal_x, req.normal_y, req.normal_z};
  assign in_l = '{req.light_dir_x, req.light_dir_y, req.light_dir_z};
  assign in_c = '{req.light_red, req.light_green, req.light_blue};

  // Stage 1: Q.14 vectors and the unnormalized half vector H = L - V.
  logic signed [15:0] s1_n [3];
  logic signed [15:0] s1_l [3];
  logic signed [16:0] s1_h [3];
  logic [CW-1:0]      s1_c [3];

  always_ff @(posedge clk) begin
    if (rdy_a[1]) begin
      for (int i = 0; i < 3; i++) begin
        s1_n[i] <= to_q14(in_n[i]);
        s1_l[i] <= to_q14(in_l[i]);
        s1_h[i] <= 17'(to_q14(in_l[i])) - 17'(to_q14(in_v[i]));
        s1_c[i] <= in_c[i];
      end
    end
  end

  // Stage 2: component products.
  logic signed [31:0] s2_nl [3];
  logic signed [32:0] s2_nh [3];
  logic        [32:0] s2_hh [3];
  logic [CW-1:0]      s2_c  [3];
  logic signed [33:0] hh_full [3];

  for (genvar i = 0; i < 3; i++) begin : g_hh
    assign hh_full[i] = s1_h[i] * s1_h[i];
  end

  always_ff @(posedge clk) begin
    if (rdy_a[2]) begin
      for (int i = 0; i < 3; i++) begin
        s2_nl[i] <= s1_n[i] * s1_l[i];
        s2_nh[i] <= s1_n[i] * s1_h[i];
        s2_hh[i] <= hh_full[i][32:0];
        s2_c[i]  <= s1_c[i];
      end
    end
  end

  // Stage 3: dot products, clamped diffuse factor and |H|^2.
  logic signed [33:0] ndl;
  logic signed [34:0] ndh;
  logic        [33:0] len2;
  logic        [19:0] ndl_q;
  logic        [14:0] d14;

  assign ndl  = 34'(s2_nl[0]) + 34'(s2_nl[1]) + 34'(s2_nl[2]);
  assign ndh  = 35'(s2_nh[0]) + 35'(s2_nh[1]) + 35'(s2_nh[2]);
  assign len2 = 34'(s2_hh[0]) + 34'(s2_hh[1]) + 34'(s2_hh[2]);
  assign ndl_q = ndl[33:14];

  always_comb begin
    if (ndl <= 34'sd0) begin
      d14 = '0;
    end else if (ndl_q > 20'(bps_pkg::ONE14)) begin
      d14 = bps_pkg::ONE14;
    end else begin
      d14 = ndl_q[14:0];
    end
  end

  logic [33:0]       s3_ndh;
  logic [33:0]       s3_len2;
  logic              s3_ok;
  logic [SIDE_W-1:0] s3_side;

  always_ff @(posedge clk) begin
    if (rdy_a[3]) begin
      s3_ndh  <= ndh[33:0];
      s3_len2 <= len2;
      // The specular base is zero for a zero-length H or a back-facing N.H.
      s3_ok   <= (len2 != '0) && (ndh > 35'sd0);
      s3_side <= {d14, s2_c[0], s2_c[1], s2_c[2]};
    end
  end

  // Square root of |H|^2, one root bit per stage.
  logic [34:0]       sq_x    [SQ];
  logic [34:0]       sq_r    [SQ];
  logic [33:0]       sq_ndh  [SQ];
  logic              sq_ok   [SQ];
  logic [SIDE_W-1:0] sq_side [SQ];

  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    localparam logic [34:0] BIT = 35'd1 << (2 * (SQ - 1 - j));
    logic [34:0]       x_in;
    logic [34:0]       r_in;
    logic [33:0]       ndh_in;
    logic              ok_in;
    logic [SIDE_W-1:0] side_w;
    logic [34:0]       trial;
    if (j == 0) begin : g_first
      assign x_in   = 35'(s3_len2);
      assign r_in   = '0;
      assign ndh_in = s3_ndh;
      assign ok_in  = s3_ok;
      assign side_w = s3_side;
    end else begin : g_next
      assign x_in   = sq_x[j-1];
      assign r_in   = sq_r[j-1];
      assign ndh_in = sq_ndh[j-1];
      assign ok_in  = sq_ok[j-1];
      assign side_w = sq_side[j-1];
    end
    assign trial = r_in + BIT;
    always_ff @(posedge clk) begin
      if (rdy_a[ST_SQRT+j]) begin
        if (x_in >= trial) begin
          sq_x[j] <= x_in - trial;
          sq_r[j] <= (r_in >> 1) + BIT;
        end else begin
          sq_x[j] <= x_in;
          sq_r[j] <= r_in >> 1;
        end
        sq_ndh[j]  <= ndh_in;
        sq_ok[j]   <= ok_in;
        sq_side[j] <= side_w;
      end
    end
  end

  // Division setup: a quotient of 2^15 or more is clamped to 1.0 anyway.
  logic [16:0]       root;
  logic [31:0]       dp_rem;
  logic [16:0]       dp_len;
  logic              dp_ovf;
  logic              dp_ok;
  logic [SIDE_W-1:0] dp_side;

  assign root = sq_r[SQ-1][16:0];

  always_ff @(posedge clk) begin
    if (rdy_a[ST_DPRE]) begin
      dp_rem  <= sq_ndh[SQ-1][31:0];
      dp_len  <= root;
      dp_ovf  <= sq_ndh[SQ-1] >= (34'(root) << 15);
      dp_ok   <= sq_ok[SQ-1];
      dp_side <= sq_side[SQ-1];
    end
  end

  // Restoring division N.H / |H|, one quotient bit per stage.
  logic [31:0]       dv_rem  [DV];
  logic [DV-1:0]     dv_q    [DV];
  logic [16:0]       dv_len  [DV];
  logic              dv_ovf  [DV];
  logic              dv_ok   [DV];
  logic [SIDE_W-1:0] dv_side [DV];

  for (genvar j = 0; j < DV; j++) begin : g_div
    logic [31:0]       rem_in;
    logic [DV-1:0]     q_in;
    logic [16:0]       len_in;
    logic              ovf_in;
    logic              ok_in;
    logic [SIDE_W-1:0] side_w;
    logic [31:0]       trial;
    if (j == 0) begin : g_first
      assign rem_in = dp_rem;
      assign q_in   = '0;
      assign len_in = dp_len;
      assign ovf_in = dp_ovf;
      assign ok_in  = dp_ok;
      assign side_w = dp_side;
    end else begin : g_next
      assign rem_in = dv_rem[j-1];
      assign q_in   = dv_q[j-1];
      assign len_in = dv_len[j-1];
      assign ovf_in = dv_ovf[j-1];
      assign ok_in  = dv_ok[j-1];
      assign side_w = dv_side[j-1];
    end
    assign trial = 32'(len_in) << (DV - 1 - j);
    always_ff @(posedge clk) begin
      if (rdy_a[ST_DIV+j]) begin
        if (rem_in >= trial) begin
          dv_rem[j] <= rem_in - trial;
          dv_q[j]   <= {q_in[DV-2:0], 1'b1};
        end else begin
          dv_rem[j] <= rem_in;
          dv_q[j]   <= {q_in[DV-2:0], 1'b0};
        end
        dv_len[j]  <= len_in;
        dv_ovf[j]  <= ovf_in;
        dv_ok[j]   <= ok_in;
        dv_side[j] <= side_w;
      end
    end
  end

  logic [bps_pkg::BASE_W-1:0] pw_base;

  always_comb begin
    if (!dv_ok[DV-1]) begin
      pw_base = '0;
    end else if (dv_ovf[DV-1] || dv_q[DV-1] > bps_pkg::ONE14) begin
      pw_base = bps_pkg::ONE14;
    end else begin
      pw_base = dv_q[DV-1];
    end
  end

  // Specular factor.
  logic                         pw_valid;
  logic                         pw_ready;
  logic [bps_pkg::FACTOR_W-1:0] pw_factor;
  logic [SIDE_W-1:0]            pw_side;

  bps_power #(
    .SIDE_W (SIDE_W)
  ) u_power (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld_a[NA]),
    .in_ready  (pw_in_ready),
    .base      (pw_base),
    .shininess (shininess),
    .side_in   (dv_side[DV-1]),
    .out_valid (pw_valid),
    .out_ready (pw_ready),
    .factor    (pw_factor),
    .side_out  (pw_side)
  );

  // Back pipeline: color terms and saturating sum.
  logic [NB:1]   vld_b;
  logic [NB+1:1] rdy_b;
  logic [NB:1]   vld_b_prev;

  assign vld_b_prev = {vld_b[NB-1:1], pw_valid};
  assign rdy_b[NB+1] = rsp.ready;
  assign pw_ready = rdy_b[1];
  assign rsp.valid = vld_b[NB];

  for (genvar k = 1; k <= NB; k++) begin : g_rdy_b
    assign rdy_b[k] = !vld_b[k] || rdy_b[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_b <= '0;
    end else begin
      for (int k = 1; k <= NB; k++) begin
        if (rdy_b[k]) begin
          vld_b[k] <= vld_b_prev[k];
        end
      end
    end
  end

  logic [14:0]   pw_d14;
  logic [CW-1:0] pw_c [3];

  assign pw_d14  = pw_side[SIDE_W-1:3*CW];
  assign pw_c[0] = pw_side[3*CW-1:2*CW];
  assign pw_c[1] = pw_side[2*CW-1:CW];
  assign pw_c[2] = pw_side[CW-1:0];

  // Term stage 1: factor times material.
  logic [CW+14:0] dif_p [3];
  logic [CW+30:0] spc_p [3];
  logic [CW:0]    t1_d  [3];
  logic [CW:0]    t1_s  [3];
  logic [CW-1:0]  t1_c  [3];

  for (genvar i = 0; i < 3; i++) begin : g_t1
    assign dif_p[i] = pw_d14 * mat_dif[i];
    assign spc_p[i] = pw_factor * mat_spc[i];
  end

  always_ff @(posedge clk) begin
    if (rdy_b[1]) begin
      for (int i = 0; i < 3; i++) begin
        t1_d[i] <= dif_p[i][CW+14:14];
        t1_s[i] <= spc_p[i][CW+30:30];
        t1_c[i] <= pw_c[i];
      end
    end
  end

  // Term stage 2: times the light color.
  logic [2*CW:0] dl_p [3];
  logic [2*CW:0] sl_p [3];
  logic [CW:0]   t2_d [3];
  logic [CW:0]   t2_s [3];

  for (genvar i = 0; i < 3; i++) begin : g_t2
    assign dl_p[i] = t1_d[i] * t1_c[i];
    assign sl_p[i] = t1_s[i] * t1_c[i];
  end

  always_ff @(posedge clk) begin
    if (rdy_b[2]) begin
      for (int i = 0; i < 3; i++) begin
        t2_d[i] <= dl_p[i][2*CW:CW];
        t2_s[i] <= sl_p[i][2*CW:CW];
      end
    end
  end

  // Term stage 3: sum and saturate.
  logic [CW+1:0] sum  [3];
  logic [CW:0]   shade [3];

  for (genvar i = 0; i < 3; i++) begin : g_t3
    assign sum[i] = {1'b0, t2_d[i]} + {1'b0, t2_s[i]};
  end

  always_ff @(posedge clk) begin
    if (rdy_b[3]) begin
      for (int i = 0; i < 3; i++) begin
        shade[i] <= sum[i][CW+1] ? '1 : sum[i][CW:0];
      end
    end
  end

  assign rsp.shade_red   = shade[0];
  assign rsp.shade_green = shade[1];
  assign rsp.shade_blue  = shade[2];

`ifndef SYNTHESIS
  // The root of a square length below 3 * 2^32 fits in 17 bits.
  a_root_width: assert property (@(posedge clk) disable iff (rst)
    vld_a[ST_DPRE-1] |-> (sq_r[SQ-1][34:17] == '0))
    else $error("square root exceeds 17 bits");

  // The specular base handed to the power unit never exceeds 1.0.
  a_base_range: assert property (@(posedge clk) disable iff (rst)
    vld_a[NA] |-> (pw_base <= bps_pkg::ONE14))
    else $error("specular base above one");

  // The power of a base at most 1.0 is at most 1.0.
  a_factor_range: assert property (@(posedge clk) disable iff (rst)
    pw_valid |-> (pw_factor <= bps_pkg::ONE30))
    else $error("specular factor above one");

  // A result waiting at the output is never overwritten by the stage behind it.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (vld_b[NB] && !rsp.ready) |=> (vld_b[NB] && $stable(shade[0])))
    else $error("stalled result lost");
`endif

endmodule

`default_nettype wire

[src/bps_power.sv]
// Pipelined power unit: base^shininess through a squaring log2 and a table exp2.
// Depends on bps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bps_power #(
  parameter int SIDE_W = 63
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bps_pkg::BASE_W-1:0]    base,
  input  logic [15:0]                   shininess,
  input  logic [SIDE_W-1:0]             side_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bps_pkg::FACTOR_W-1:0]  factor,
  output logic [SIDE_W-1:0]             side_out
);

  localparam int LB    = bps_pkg::LOG_BITS;
  localparam int ST_SQ = 2;
  localparam int ST_Y  = ST_SQ + LB;
  localparam int ST_EX = ST_Y + 1;
  localparam int NP    = ST_EX + LB;

  logic [NP:1]   vld;
  logic [NP+1:1] rdy;
  logic [NP:1]   vld_prev;

  assign vld_prev = {vld[NP-1:1], in_valid};
  assign rdy[NP+1] = out_ready;
  assign in_ready = rdy[1];
  assign out_valid = vld[NP];

  for (genvar k = 1; k <= NP; k++) begin : g_rdy
    assign rdy[k] = !vld[k] || rdy[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 1; k <= NP; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld_prev[k];
        end
      end
    end
  end

  // Normalize the base so that its leading one sits at bit 15, and flag a zero shininess or a zero base.
  logic [3:0]        msb;
  logic [3:0]        p0_ilog;
  logic [15:0]       p0_m;
  bps_pkg::pw_code_t p0_code;
  logic [SIDE_W-1:0] p0_side;

  always_comb begin
    msb = '0;
    for (int i = 0; i < bps_pkg::BASE_W; i++) begin
      if (base[i]) begin
        msb = 4'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      p0_ilog <= 4'd14 - msb;
      p0_m    <= 16'({1'b0, base} << (4'd15 - msb));
      p0_side <= side_in;
      if (shininess == '0) begin
        p0_code <= bps_pkg::PW_ONE;
      end else if (base == '0) begin
        p0_code <= bps_pkg::PW_ZERO;
      end else begin
        p0_code <= bps_pkg::PW_CALC;
      end
    end
  end

  // One fraction bit of log2 per stage by squaring the mantissa.
  logic [15:0]       sq_m    [LB];
  logic [LB-1:0]     sq_f    [LB];
  logic [3:0]        sq_ilog [LB];
  bps_pkg::pw_code_t sq_code [LB];
  logic [SIDE_W-1:0] sq_side [LB];

  for (genvar j = 0; j < LB; j++) begin : g_log
    logic [15:0]       m_in;
    logic [LB-1:0]     f_in;
    logic [3:0]        ilog_in;
    bps_pkg::pw_code_t code_in;
    logic [SIDE_W-1:0] side_w;
    logic [31:0]       sq;
    if (j == 0) begin : g_first
      assign m_in    = p0_m;
      assign f_in    = '0;
      assign ilog_in = p0_ilog;
      assign code_in = p0_code;
      assign side_w  = p0_side;
    end else begin : g_next
      assign m_in    = sq_m[j-1];
      assign f_in    = sq_f[j-1];
      assign ilog_in = sq_ilog[j-1];
      assign code_in = sq_code[j-1];
      assign side_w  = sq_side[j-1];
    end
    assign sq = m_in * m_in;
    always_ff @(posedge clk) begin
      if (rdy[ST_SQ+j]) begin
        if (sq[31]) begin
          sq_m[j] <= sq[31:16];
          sq_f[j] <= {f_in[LB-2:0], 1'b1};
        end else begin
          sq_m[j] <= sq[30:15];
          sq_f[j] <= {f_in[LB-2:0], 1'b0};
        end
        sq_ilog[j] <= ilog_in;
        sq_code[j] <= code_in;
        sq_side[j] <= side_w;
      end
    end
  end

  // Scale -log2(base) by the shininess in Q8.8.
  logic [19:0]       nl;
  logic [35:0]       y_prod;
  logic [11:0]       y_int;
  logic [15:0]       y_frac;
  bps_pkg::pw_code_t y_code;
  logic [SIDE_W-1:0] y_side;

  assign nl = {sq_ilog[LB-1], 16'h0000} - {4'h0, sq_f[LB-1]};
  assign y_prod = shininess * nl;

  always_ff @(posedge clk) begin
    if (rdy[ST_Y]) begin
      y_int  <= y_prod[35:24];
      y_frac <= y_prod[23:8];
      y_code <= sq_code[LB-1];
      y_side <= sq_side[LB-1];
    end
  end

  // exp2 of the fraction: one table factor per stage.
  logic [bps_pkg::FACTOR_W-1:0] ex_acc  [LB];
  logic [15:0]                  ex_frac [LB];
  logic [4:0]                   ex_sh   [LB];
  bps_pkg::pw_code_t            ex_code [LB];
  logic [SIDE_W-1:0]            ex_side [LB];

  for (genvar j = 0; j < LB; j++) begin : g_exp
    localparam logic [29:0] TAB = bps_pkg::exp_tab(j + 1);
    logic [bps_pkg::FACTOR_W-1:0] acc_in;
    logic [15:0]                  frac_in;
    logic [4:0]                   sh_in;
    bps_pkg::pw_code_t            code_in;
    logic [SIDE_W-1:0]            side_w;
    logic [60:0]                  prod;
    if (j == 0) begin : g_first
      assign acc_in  = bps_pkg::ONE30;
      assign frac_in = y_frac;
      assign sh_in   = y_int[4:0];
      assign side_w  = y_side;
      // A shift of 31 or more leaves nothing of the factor.
      assign code_in = (y_code == bps_pkg::PW_CALC && y_int >= 12'd31) ?
                       bps_pkg::PW_ZERO : y_code;
    end else begin : g_next
      assign acc_in  = ex_acc[j-1];
      assign frac_in = ex_frac[j-1];
      assign sh_in   = ex_sh[j-1];
      assign code_in = ex_code[j-1];
      assign side_w  = ex_side[j-1];
    end
    assign prod = acc_in * TAB;
    always_ff @(posedge clk) begin
      if (rdy[ST_EX+j]) begin
        ex_acc[j]  <= frac_in[LB-1-j] ? prod[60:30] : acc_in;
        ex_frac[j] <= frac_in;
        ex_sh[j]   <= sh_in;
        ex_code[j] <= code_in;
        ex_side[j] <= side_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NP]) begin
      side_out <= ex_side[LB-1];
      case (ex_code[LB-1])
        bps_pkg::PW_ONE:  factor <= bps_pkg::ONE30;
        bps_pkg::PW_ZERO: factor <= '0;
        default:          factor <= ex_acc[LB-1] >> ex_sh[LB-1];
      endcase
    end
  end

endmodule

`default_nettype wire
